// ----- src/limit_order_book_matcher_assert.svh -----
// Assertion macros for the order book matcher.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
// same-cycle implication
`define LOBM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LOBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- src/lobm_pkg.sv -----
// Shared types, sizes, codes and helper functions of the order book matcher.
// No dependencies; lobm_alu, lobm_book and the top level import it.
package lobm_pkg;

	localparam int LEVELS_PER_SIDE = 4;
	localparam int SLOTS_PER_LEVEL = 4;
	localparam int NLEV = 2 * LEVELS_PER_SIDE;
	localparam int NSLOT = NLEV * SLOTS_PER_LEVEL;
	localparam int MAX_RESULTS = 33;

	localparam int PRICE_W = 32;
	localparam int QTY_W = 48;
	localparam int ID_W = 32;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 144;

	localparam int LVL_W = $clog2(NLEV);
	localparam int POS_W = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
	localparam int LCNT_W = $clog2(LEVELS_PER_SIDE + 1);
	localparam int SLOT_W = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
	localparam int SCNT_W = $clog2(SLOTS_PER_LEVEL + 1);
	localparam int SIDX_W = $clog2(NSLOT);
	localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [LVL_W-1:0] BID0 = LVL_W'(0);
	localparam logic [LVL_W-1:0] ASK0 = LVL_W'(LEVELS_PER_SIDE);

	typedef logic [PRICE_W-1:0] price_t;
	typedef logic [QTY_W-1:0] qty_t;
	typedef logic [ID_W-1:0] id_t;

	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_LIMIT = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [2:0] RES_FILL = 3'd0;
	localparam logic [2:0] RES_DONE = 3'd1;
	localparam logic [2:0] RES_RESTED = 3'd2;
	localparam logic [2:0] RES_DUP = 3'd3;
	localparam logic [2:0] RES_FULL = 3'd4;
	localparam logic [2:0] RES_BADID = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_UPD, ST_M_TOP, ST_M_OUTER, ST_M_INNER, ST_M_BSTEP,
		ST_M_LEVEND, ST_DUP, ST_SWEEP, ST_FILL, ST_L_LEVEND, ST_REST, ST_PLACE, ST_FINAL
	} st_t;

	typedef enum logic [2:0] {
		BOP_NONE, BOP_CLEAR, BOP_LEV_REMOVE, BOP_LEV_INSERT, BOP_SLOT_AMT,
		BOP_SLOT_APPEND, BOP_SLOT_REMOVE
	} book_op_t;

	typedef struct packed {
		book_op_t op;
		logic side;
		logic [POS_W-1:0] pos;
		logic [LVL_W-1:0] lvl;
		logic [SLOT_W-1:0] slot;
		logic feed;
		price_t price;
		id_t owner;
		qty_t amt;
		logic wa_en;
		logic [LVL_W-1:0] wa_lvl;
		logic [SLOT_W-1:0] wa_slot;
		qty_t wa_amt;
	} book_cmd_t;

	function automatic logic [LVL_W-1:0] lvl_idx(input logic side, input int pos);
		return LVL_W'(int'(side) * LEVELS_PER_SIDE + pos);
	endfunction

	function automatic logic [SIDX_W-1:0] slot_idx(input logic [LVL_W-1:0] lv, input int k);
		return SIDX_W'(int'(lv) * SLOTS_PER_LEVEL + k);
	endfunction

	function automatic logic [LCNT_W-1:0] lev_count(input logic [NLEV-1:0] lu, input logic side);
		logic run;
		logic [LCNT_W-1:0] n;
		run = 1'b1;
		n = '0;
		for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
			if (run && lu[int'(side) * LEVELS_PER_SIDE + i]) n = n + LCNT_W'(1);
			else run = 1'b0;
		end
		return n;
	endfunction

	function automatic logic [SCNT_W-1:0] slot_count(input logic [NSLOT-1:0] su,
		input logic [LVL_W-1:0] lv);
		logic run;
		logic [SCNT_W-1:0] n;
		run = 1'b1;
		n = '0;
		for (int k = 0; k < SLOTS_PER_LEVEL; k++) begin
			if (run && su[int'(lv) * SLOTS_PER_LEVEL + k]) n = n + SCNT_W'(1);
			else run = 1'b0;
		end
		return n;
	endfunction

endpackage

// ----- src/lobm_alu.sv -----
// Shared fill unit: minimum of two quantities and what remains of each.
// Depends on lobm_pkg.
module lobm_alu import lobm_pkg::*; (
	input  qty_t a,
	input  qty_t b,
	output qty_t mn,
	output qty_t a_rest,
	output qty_t b_rest
);

	assign mn = (a < b) ? a : b;
	assign a_rest = a - mn;
	assign b_rest = b - mn;

endmodule

// ----- src/lobm_book.sv -----
// Book storage: level rows and order slots, with row shift, slot shift and
// amount writes under command of the sequencer. Depends on lobm_pkg.
module lobm_book import lobm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  book_cmd_t        cmd,
	output logic [NLEV-1:0]  lused,
	output price_t           lprice [NLEV],
	output logic [NSLOT-1:0] sused,
	output id_t              owner [NSLOT],
	output qty_t             amt [NSLOT]
);

	logic [NLEV-1:0] lused_q, n_lused;
	price_t lprice_q [NLEV];
	price_t n_lprice [NLEV];
	logic [NSLOT-1:0] sused_q, n_sused;
	id_t owner_q [NSLOT];
	id_t n_owner [NSLOT];
	qty_t amt_q [NSLOT];
	qty_t n_amt [NSLOT];

	always_comb begin
		logic [LCNT_W-1:0] lcnt;
		logic [SCNT_W-1:0] scnt;
		int d;
		n_lused = lused_q;
		n_lprice = lprice_q;
		n_sused = sused_q;
		n_owner = owner_q;
		n_amt = amt_q;
		lcnt = lev_count(lused_q, cmd.side);
		scnt = slot_count(sused_q, cmd.lvl);
		d = 0;
		if (cmd.wa_en) n_amt[slot_idx(cmd.wa_lvl, int'(cmd.wa_slot))] = cmd.wa_amt;
		case (cmd.op)
			BOP_CLEAR: begin
				n_lused = '0;
				n_sused = '0;
			end
			BOP_LEV_REMOVE: begin
				// close the gap: pull later rows up by one
				for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
					d = int'(cmd.side) * LEVELS_PER_SIDE + i;
					if (i >= int'(cmd.pos) && i + 1 < int'(lcnt)) begin
						n_lprice[d] = lprice_q[d + 1];
						n_lused[d] = lused_q[d + 1];
						for (int k = 0; k < SLOTS_PER_LEVEL; k++) begin
							n_owner[d * SLOTS_PER_LEVEL + k] = owner_q[(d + 1) * SLOTS_PER_LEVEL + k];
							n_amt[d * SLOTS_PER_LEVEL + k] = amt_q[(d + 1) * SLOTS_PER_LEVEL + k];
							n_sused[d * SLOTS_PER_LEVEL + k] = sused_q[(d + 1) * SLOTS_PER_LEVEL + k];
						end
					end
					if (i + 1 == int'(lcnt)) begin
						n_lused[d] = 1'b0;
						for (int k = 0; k < SLOTS_PER_LEVEL; k++)
							n_sused[d * SLOTS_PER_LEVEL + k] = 1'b0;
					end
				end
			end
			BOP_LEV_INSERT: begin
				// open a gap at pos: push rows down by one
				for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
					d = int'(cmd.side) * LEVELS_PER_SIDE + i;
					if (i > int'(cmd.pos) && i <= int'(lcnt)) begin
						n_lprice[d] = lprice_q[d - 1];
						n_lused[d] = lused_q[d - 1];
						for (int k = 0; k < SLOTS_PER_LEVEL; k++) begin
							n_owner[d * SLOTS_PER_LEVEL + k] = owner_q[(d - 1) * SLOTS_PER_LEVEL + k];
							n_amt[d * SLOTS_PER_LEVEL + k] = amt_q[(d - 1) * SLOTS_PER_LEVEL + k];
							n_sused[d * SLOTS_PER_LEVEL + k] = sused_q[(d - 1) * SLOTS_PER_LEVEL + k];
						end
					end
					if (i == int'(cmd.pos)) begin
						n_lused[d] = 1'b1;
						n_lprice[d] = cmd.price;
						for (int k = 0; k < SLOTS_PER_LEVEL; k++)
							n_sused[d * SLOTS_PER_LEVEL + k] = 1'b0;
						if (cmd.feed) begin
							n_owner[d * SLOTS_PER_LEVEL] = '0;
							n_amt[d * SLOTS_PER_LEVEL] = cmd.amt;
							n_sused[d * SLOTS_PER_LEVEL] = 1'b1;
						end
					end
				end
			end
			BOP_SLOT_AMT: begin
				n_amt[slot_idx(cmd.lvl, int'(cmd.slot))] = cmd.amt;
			end
			BOP_SLOT_APPEND: begin
				n_owner[slot_idx(cmd.lvl, int'(scnt))] = cmd.owner;
				n_amt[slot_idx(cmd.lvl, int'(scnt))] = cmd.amt;
				n_sused[slot_idx(cmd.lvl, int'(scnt))] = 1'b1;
			end
			BOP_SLOT_REMOVE: begin
				for (int k = 0; k < SLOTS_PER_LEVEL; k++) begin
					d = int'(cmd.lvl) * SLOTS_PER_LEVEL + k;
					if (k >= int'(cmd.slot) && k + 1 < int'(scnt)) begin
						n_owner[d] = owner_q[d + 1];
						n_amt[d] = amt_q[d + 1];
					end
					if (k + 1 == int'(scnt)) n_sused[d] = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lused_q <= '0;
			sused_q <= '0;
		end else begin
			lused_q <= n_lused;
			sused_q <= n_sused;
		end
	end

	always_ff @(posedge clk) begin
		lprice_q <= n_lprice;
		owner_q <= n_owner;
		amt_q <= n_amt;
	end

	assign lused = lused_q;
	assign lprice = lprice_q;
	assign sused = sused_q;
	assign owner = owner_q;
	assign amt = amt_q;

endmodule

// ----- src/limit_order_book_matcher.sv -----
// Price-time order book matcher. One request at a time: s_tready is high only
// while idle. A clear, an unknown request or a zero id goes from the start
// state straight to the final beat. A level update writes the book, then
// matches while the best levels cross, visiting each level pair and each bid
// slot in turn. A limit order with a nonzero id scans the 32 order slots one
// per cycle for a duplicate; the scan stops at a hit. Otherwise the order
// sweeps the opposite levels, filling and emptying them, and rests what is
// left if there is room. A result beat that waits on m_tready stalls it.
// Every request ends with one beat carrying m_tlast; fill beats precede it. The
// single shared min/subtract unit handles one fill per cycle while no result
// beat waits on m_tready.
// Depends on lobm_pkg, lobm_alu, lobm_book and the assertion header.
`include "limit_order_book_matcher_assert.svh"
module limit_order_book_matcher import lobm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // price_ticks, quantity, order_id
	input  logic [2:0]            s_tuser,   // req_type, side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // buy_order_id, sell_order_id, fill_price, fill_quantity
	output logic [2:0]            m_tuser,   // result_kind
	output logic                  m_tlast
);

	st_t st_q, n_st;
	logic [1:0] req_q, n_req;
	logic side_q, n_side;
	price_t lim_q, n_lim;
	qty_t rem_q, n_rem;
	id_t id_q, n_id;
	logic [SCNT_W-1:0] bi_q, n_bi, ai_q, n_ai;
	logic [LVL_W-1:0] scl_q, n_scl;
	logic [SLOT_W-1:0] scs_q, n_scs;
	logic [POS_W-1:0] pos_q, n_pos;
	logic [2:0] fkind_q, n_fkind;
	logic fdata_q, n_fdata;
	logic [FCNT_W-1:0] fcnt_q, n_fcnt;

	logic ov_q;
	logic [2:0] okind_q;
	id_t obuy_q, osell_q;
	price_t oprice_q;
	qty_t oqty_q;
	logic olast_q;

	logic e_valid, e_last;
	logic [2:0] e_kind;
	id_t e_buy, e_sell;
	price_t e_price;
	qty_t e_qty;

	book_cmd_t cmd;
	logic [NLEV-1:0] lused;
	price_t lprice [NLEV];
	logic [NSLOT-1:0] sused;
	id_t owner [NSLOT];
	qty_t amt [NSLOT];

	qty_t alu_a, alu_b, alu_mn, alu_ar, alu_br;
	logic can_emit;

	// lookups
	logic [SCNT_W-1:0] bcnt, acnt, ocnt, pcnt, flcnt;
	logic [SIDX_W-1:0] bs, as_i, k0, di;
	logic [LVL_W-1:0] lvo, plv, fl;
	logic [LCNT_W-1:0] scnt_side, f_pos;
	logic f_found, f_done, feed_hit, dup_hit;
	logic [SLOT_W-1:0] feed_k;
	price_t lp;

	lobm_book u_book (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.lused  (lused),
		.lprice (lprice),
		.sused  (sused),
		.owner  (owner),
		.amt    (amt)
	);

	lobm_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.mn     (alu_mn),
		.a_rest (alu_ar),
		.b_rest (alu_br)
	);

	assign can_emit = !ov_q || m_tready;
	assign s_tready = (st_q == ST_IDLE);

	always_comb begin
		bcnt = slot_count(sused, BID0);
		acnt = slot_count(sused, ASK0);
		bs = slot_idx(BID0, int'(bi_q));
		as_i = slot_idx(ASK0, int'(ai_q));
		lvo = lvl_idx(~side_q, 0);
		k0 = slot_idx(lvo, 0);
		ocnt = slot_count(sused, lvo);
		plv = lvl_idx(side_q, int'(pos_q));
		pcnt = slot_count(sused, plv);
		di = slot_idx(scl_q, int'(scs_q));
		dup_hit = sused[di] && lused[scl_q] && (owner[di] == id_q);

		// sorted position of the request price on its own side
		scnt_side = lev_count(lused, side_q);
		f_found = 1'b0;
		f_done = 1'b0;
		f_pos = scnt_side;
		for (int p = 0; p < LEVELS_PER_SIDE; p++) begin
			if (!f_done && p < int'(scnt_side)) begin
				if (lprice[lvl_idx(side_q, p)] == lim_q) begin
					f_found = 1'b1;
					f_done = 1'b1;
					f_pos = LCNT_W'(p);
				end else if (side_q ? (lim_q < lprice[lvl_idx(side_q, p)])
					: (lim_q > lprice[lvl_idx(side_q, p)])) begin
					f_done = 1'b1;
					f_pos = LCNT_W'(p);
				end
			end
		end

		fl = lvl_idx(side_q, int'(f_pos));
		flcnt = slot_count(sused, fl);
		feed_hit = 1'b0;
		feed_k = '0;
		for (int k = SLOTS_PER_LEVEL - 1; k >= 0; k--) begin
			if (k < int'(flcnt) && owner[slot_idx(fl, k)] == '0) begin
				feed_hit = 1'b1;
				feed_k = SLOT_W'(k);
			end
		end

		lp = lprice[lvo];
		alu_a = (st_q == ST_FILL) ? rem_q : amt[bs];
		alu_b = (st_q == ST_FILL) ? amt[k0] : amt[as_i];
	end

	always_comb begin
		n_st = st_q;
		n_req = req_q;
		n_side = side_q;
		n_lim = lim_q;
		n_rem = rem_q;
		n_id = id_q;
		n_bi = bi_q;
		n_ai = ai_q;
		n_scl = scl_q;
		n_scs = scs_q;
		n_pos = pos_q;
		n_fkind = fkind_q;
		n_fdata = fdata_q;
		n_fcnt = fcnt_q;
		cmd = '0;
		e_valid = 1'b0;
		e_kind = RES_FILL;
		e_buy = '0;
		e_sell = '0;
		e_price = '0;
		e_qty = '0;
		e_last = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					n_req = s_tuser[1:0];
					n_side = s_tuser[2];
					n_lim = s_tdata[31:0];
					n_rem = s_tdata[79:32];
					n_id = s_tdata[111:80];
					n_fcnt = '0;
					n_st = ST_START;
				end
			end
			ST_START: begin
				n_fdata = 1'b0;
				n_fkind = RES_DONE;
				case (req_q)
					REQ_UPDATE: n_st = ST_UPD;
					REQ_LIMIT: begin
						if (id_q == '0) begin
							n_fkind = RES_BADID;
							n_st = ST_FINAL;
						end else begin
							n_scl = '0;
							n_scs = '0;
							n_st = ST_DUP;
						end
					end
					REQ_CLEAR: begin
						cmd.op = BOP_CLEAR;
						n_st = ST_FINAL;
					end
					default: n_st = ST_FINAL;
				endcase
			end
			ST_UPD: begin
				n_st = ST_M_TOP;
				cmd.side = side_q;
				cmd.pos = f_pos[POS_W-1:0];
				cmd.lvl = fl;
				cmd.price = lim_q;
				cmd.amt = rem_q;
				if (rem_q == '0) begin
					if (f_found) cmd.op = BOP_LEV_REMOVE;
				end else if (f_found) begin
					if (feed_hit) begin
						cmd.op = BOP_SLOT_AMT;
						cmd.slot = feed_k;
					end else if (flcnt < SCNT_W'(SLOTS_PER_LEVEL)) begin
						cmd.op = BOP_SLOT_APPEND;
					end else begin
						n_fkind = RES_FULL;
					end
				end else if (scnt_side < LCNT_W'(LEVELS_PER_SIDE)) begin
					cmd.op = BOP_LEV_INSERT;
					cmd.feed = 1'b1;
				end else begin
					n_fkind = RES_FULL;
				end
			end
			ST_M_TOP: begin
				if (!lused[BID0] || !lused[ASK0] || lprice[BID0] < lprice[ASK0]) begin
					n_st = ST_FINAL;
				end else begin
					n_bi = '0;
					n_st = ST_M_OUTER;
				end
			end
			ST_M_OUTER: begin
				if (bi_q < bcnt && acnt != '0) begin
					n_ai = '0;
					n_st = ST_M_INNER;
				end else begin
					n_st = ST_M_LEVEND;
				end
			end
			ST_M_INNER: begin
				if (ai_q < acnt && amt[bs] != '0) begin
					if (owner[bs] == '0 && owner[as_i] == '0) begin
						// two feed slots never trade
						n_st = ST_M_BSTEP;
					end else if (fcnt_q < FCNT_W'(MAX_RESULTS - 1) && !can_emit) begin
						n_st = st_q;
					end else begin
						if (fcnt_q < FCNT_W'(MAX_RESULTS - 1)) begin
							e_valid = 1'b1;
							e_buy = owner[bs];
							e_sell = owner[as_i];
							e_price = lprice[ASK0];
							e_qty = alu_mn;
							n_fcnt = fcnt_q + FCNT_W'(1);
						end
						cmd.wa_en = 1'b1;
						cmd.wa_lvl = BID0;
						cmd.wa_slot = bi_q[SLOT_W-1:0];
						cmd.wa_amt = alu_ar;
						cmd.lvl = ASK0;
						cmd.slot = ai_q[SLOT_W-1:0];
						cmd.amt = alu_br;
						if (alu_br == '0) begin
							cmd.op = BOP_SLOT_REMOVE;
						end else begin
							cmd.op = BOP_SLOT_AMT;
							n_ai = ai_q + SCNT_W'(1);
						end
					end
				end else begin
					n_st = ST_M_BSTEP;
				end
			end
			ST_M_BSTEP: begin
				if (amt[bs] == '0) begin
					cmd.op = BOP_SLOT_REMOVE;
					cmd.lvl = BID0;
					cmd.slot = bi_q[SLOT_W-1:0];
				end else begin
					n_bi = bi_q + SCNT_W'(1);
				end
				n_st = ST_M_OUTER;
			end
			ST_M_LEVEND: begin
				cmd.pos = '0;
				if (bcnt == '0) begin
					cmd.op = BOP_LEV_REMOVE;
					cmd.side = 1'b0;
					n_st = ST_M_TOP;
				end else if (acnt == '0) begin
					cmd.op = BOP_LEV_REMOVE;
					cmd.side = 1'b1;
					n_st = ST_M_TOP;
				end else begin
					n_st = ST_FINAL;
				end
			end
			ST_DUP: begin
				if (dup_hit) begin
					n_fkind = RES_DUP;
					n_st = ST_FINAL;
				end else if (scl_q == LVL_W'(NLEV - 1) && scs_q == SLOT_W'(SLOTS_PER_LEVEL - 1)) begin
					n_st = ST_SWEEP;
				end else if (scs_q == SLOT_W'(SLOTS_PER_LEVEL - 1)) begin
					n_scs = '0;
					n_scl = scl_q + LVL_W'(1);
				end else begin
					n_scs = scs_q + SLOT_W'(1);
				end
			end
			ST_SWEEP: begin
				if (rem_q == '0 || !lused[lvo] || (side_q ? (lim_q > lp) : (lim_q < lp)))
					n_st = ST_REST;
				else
					n_st = ST_FILL;
			end
			ST_FILL: begin
				if (rem_q != '0 && ocnt != '0) begin
					if (fcnt_q < FCNT_W'(MAX_RESULTS - 1) && !can_emit) begin
						n_st = st_q;
					end else begin
						if (fcnt_q < FCNT_W'(MAX_RESULTS - 1)) begin
							e_valid = 1'b1;
							e_buy = side_q ? owner[k0] : id_q;
							e_sell = side_q ? id_q : owner[k0];
							e_price = lp;
							e_qty = alu_mn;
							n_fcnt = fcnt_q + FCNT_W'(1);
						end
						n_rem = alu_ar;
						cmd.lvl = lvo;
						cmd.slot = '0;
						cmd.amt = alu_br;
						cmd.op = (alu_br == '0) ? BOP_SLOT_REMOVE : BOP_SLOT_AMT;
					end
				end else begin
					n_st = ST_L_LEVEND;
				end
			end
			ST_L_LEVEND: begin
				if (ocnt == '0) begin
					cmd.op = BOP_LEV_REMOVE;
					cmd.side = ~side_q;
					cmd.pos = '0;
					n_st = ST_SWEEP;
				end else begin
					n_st = ST_REST;
				end
			end
			ST_REST: begin
				if (rem_q == '0) begin
					n_fkind = RES_DONE;
					n_st = ST_FINAL;
				end else if (f_found) begin
					n_pos = f_pos[POS_W-1:0];
					n_st = ST_PLACE;
				end else if (scnt_side < LCNT_W'(LEVELS_PER_SIDE)) begin
					cmd.op = BOP_LEV_INSERT;
					cmd.side = side_q;
					cmd.pos = f_pos[POS_W-1:0];
					cmd.price = lim_q;
					n_pos = f_pos[POS_W-1:0];
					n_st = ST_PLACE;
				end else begin
					n_fkind = RES_FULL;
					n_fdata = 1'b1;
					n_st = ST_FINAL;
				end
			end
			ST_PLACE: begin
				n_fdata = 1'b1;
				n_st = ST_FINAL;
				if (pcnt < SCNT_W'(SLOTS_PER_LEVEL)) begin
					cmd.op = BOP_SLOT_APPEND;
					cmd.lvl = plv;
					cmd.owner = id_q;
					cmd.amt = rem_q;
					n_fkind = RES_RESTED;
				end else begin
					n_fkind = RES_FULL;
				end
			end
			ST_FINAL: begin
				if (can_emit) begin
					e_valid = 1'b1;
					e_kind = fkind_q;
					e_last = 1'b1;
					if (fdata_q) begin
						e_buy = side_q ? '0 : id_q;
						e_sell = side_q ? id_q : '0;
						e_price = lim_q;
						e_qty = rem_q;
					end
					n_st = ST_IDLE;
				end
			end
			default: n_st = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= n_st;
			if (e_valid) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= n_req;
		side_q <= n_side;
		lim_q <= n_lim;
		rem_q <= n_rem;
		id_q <= n_id;
		bi_q <= n_bi;
		ai_q <= n_ai;
		scl_q <= n_scl;
		scs_q <= n_scs;
		pos_q <= n_pos;
		fkind_q <= n_fkind;
		fdata_q <= n_fdata;
		fcnt_q <= n_fcnt;
		if (e_valid) begin
			okind_q <= e_kind;
			obuy_q <= e_buy;
			osell_q <= e_sell;
			oprice_q <= e_price;
			oqty_q <= e_qty;
			olast_q <= e_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = {oqty_q, oprice_q, osell_q, obuy_q};
	assign m_tuser = okind_q;
	assign m_tlast = olast_q;

	`LOBM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
	`LOBM_ASSERT_SAME(a_fill_not_last, m_tvalid && m_tuser == RES_FILL, !m_tlast, "fill marked last")
	`LOBM_ASSERT_NEXT(a_final_to_idle, st_q == ST_FINAL && can_emit, s_tready, "no idle after final beat")

endmodule
